/* design/ptc_pkg.sv */
// Shared widths, reset values, register indexes and types for the PID temperature controller.
package ptc_pkg;

    localparam int TEMP_W     = 10;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 10;
    localparam int ERR_W      = 11;
    localparam int DERR_W     = 12;
    localparam int MAG_DE_W   = 11;
    localparam int FRAC_W     = 32;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 12;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int P1_W       = 42;
    localparam int INTEG_W    = 42;
    localparam int INC_W      = INTEG_W + 1;
    localparam int ACC_W      = P1_W + TIME_W;
    localparam int DIV_SHIFT  = 12;
    localparam int DIVD_W     = 55;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int SUM_W      = 57;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 16;

    localparam logic [GAIN_W-1:0] KP_RESET   = 32'd2097152;
    localparam logic [GAIN_W-1:0] KI_RESET   = 32'd171799;
    localparam logic [GAIN_W-1:0] KD_RESET   = 32'd3670016000;
    localparam logic [LIM_W-1:0]  BAND_RESET = 10'd20;
    localparam logic [LIM_W-1:0]  LIM_RESET  = 10'd250;

    localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_GAIN      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KD_GAIN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_BAND   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_op_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_MKD  = 15'h0002,
        ST_MKI  = 15'h0004,
        ST_MKP  = 15'h0008,
        ST_MDT3 = 15'h0010,
        ST_MDT2 = 15'h0020,
        ST_MDT1 = 15'h0040,
        ST_MDT0 = 15'h0080,
        ST_ACC  = 15'h0100,
        ST_INC  = 15'h0200,
        ST_UPD  = 15'h0400,
        ST_WAIT = 15'h0800,
        ST_SUM1 = 15'h1000,
        ST_SUM2 = 15'h2000,
        ST_OUT  = 15'h4000
    } state_t;

endpackage

/* design/pid_temperature_controller.sv */
// Top level of the PID temperature controller: sequencer, state, config and output register.
//
//   Channel  Direction  Beat contents
//   s_       in         tdata: measured_temp[9:0], target_temp[19:10], now_ms[51:20]
//   m_       out        tdata: drive[9:0]; tuser: no_elapsed_time
//   cfg_     in         cfg_addr selects kp, ki, kd, error_band, output_limit (0..4)
//
// From acceptance, a beat waits on the 55-step restoring divider for the derivative
// term before its result is loaded; the multiply steps on the shared multiplier
// and the integral steps run while the divider works.
// Reset clears the controller state and gains to their defaults; no clearing pass.
// s_tready is high only while the sequencer is idle; a result that is not taken
// holds the sequencer in its last step, which keeps the input side blocked.
module pid_temperature_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptc_pkg::S_TDATA_W-1:0]     s_tdata,  // measured_temp, target_temp, now_ms
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptc_pkg::M_TDATA_W-1:0]     m_tdata,  // drive
    output logic                              m_tuser,  // no_elapsed_time
    input  logic                              cfg_we,
    input  logic [ptc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int TW = ptc_pkg::TEMP_W;
    localparam int SW = ptc_pkg::SUM_W;

    ptc_pkg::state_t state_reg, state_next;

    logic [ptc_pkg::GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [ptc_pkg::LIM_W-1:0]  band_reg, limit_reg;

    logic [ptc_pkg::TIME_W-1:0]  last_time_reg;
    logic [ptc_pkg::ERR_W-1:0]   last_err_reg;
    logic [ptc_pkg::INTEG_W-1:0] integ_reg, integ_next;

    logic [ptc_pkg::TIME_W-1:0]   dt_reg;
    logic [ptc_pkg::ERR_W-1:0]    err_reg;
    logic [TW-1:0]                mag_e_reg;
    logic [ptc_pkg::MAG_DE_W-1:0] mag_de_reg;
    logic                         de_neg_reg;
    logic [ptc_pkg::P1_W-1:0]     p1_reg;
    logic [ptc_pkg::P1_W-1:0]     pmag_reg;
    logic [ptc_pkg::ACC_W-1:0]    acc_reg, acc_step;
    logic [ptc_pkg::INC_W-1:0]    inc_reg, inc_next;
    logic [SW-1:0]                sum_reg;

    logic                         out_valid_reg;
    logic [ptc_pkg::LIM_W-1:0]    out_drive_reg, drive_next;
    logic                         out_flag_reg;

    logic                         in_beat;
    logic                         out_load;
    logic [TW-1:0]                in_meas, in_targ;
    logic [ptc_pkg::TIME_W-1:0]   in_now;
    logic [ptc_pkg::ERR_W-1:0]    err_in;
    logic [ptc_pkg::DERR_W-1:0]   de_in;

    ptc_pkg::mul_op_t             mul_op;
    logic [ptc_pkg::MUL_P_W-1:0]  mul_p;
    ptc_pkg::div_req_t            div_req;
    logic                         div_busy;
    logic [ptc_pkg::DIVD_W-1:0]   div_q;

    logic [ptc_pkg::INTEG_W-1:0]  cap;
    logic                         dt_zero;
    logic [ptc_pkg::INTEG_W+1:0]  integ_sum;
    logic [ptc_pkg::INTEG_W-1:0]  integ_dec;
    logic [SW-1:0]                p_ext, p_s, d_ext, d_s;
    logic [SW-ptc_pkg::FRAC_W-1:0] sum_hi;

    assign in_meas = s_tdata[TW-1:0];
    assign in_targ = s_tdata[2*TW-1:TW];
    assign in_now  = s_tdata[2*TW+ptc_pkg::TIME_W-1:2*TW];

    assign s_tready = state_reg == ptc_pkg::ST_IDLE;
    assign in_beat  = s_tvalid && s_tready;
    assign out_load = (state_reg == ptc_pkg::ST_OUT) && (!out_valid_reg || m_tready);

    assign err_in = {1'b0, in_targ} - {1'b0, in_meas};
    assign de_in  = {err_in[ptc_pkg::ERR_W-1], err_in}
                  - {last_err_reg[ptc_pkg::ERR_W-1], last_err_reg};

    assign cap     = {limit_reg, {ptc_pkg::FRAC_W{1'b0}}};
    assign dt_zero = dt_reg == '0;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= ptc_pkg::KP_RESET;
            ki_reg    <= ptc_pkg::KI_RESET;
            kd_reg    <= ptc_pkg::KD_RESET;
            band_reg  <= ptc_pkg::BAND_RESET;
            limit_reg <= ptc_pkg::LIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ptc_pkg::REG_KP_GAIN:      kp_reg    <= cfg_wdata;
                ptc_pkg::REG_KI_GAIN:      ki_reg    <= cfg_wdata;
                ptc_pkg::REG_KD_GAIN:      kd_reg    <= cfg_wdata;
                ptc_pkg::REG_ERROR_BAND:   band_reg  <= cfg_wdata[ptc_pkg::LIM_W-1:0];
                ptc_pkg::REG_OUTPUT_LIMIT: limit_reg <= cfg_wdata[ptc_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier, whose product is registered.
    always_comb begin
        mul_op = '0;
        unique case (state_reg)
            ptc_pkg::ST_MKD: begin
                mul_op.a = kd_reg;
                mul_op.b = ptc_pkg::MUL_B_W'(mag_de_reg);
            end
            ptc_pkg::ST_MKI: begin
                mul_op.a = ki_reg;
                mul_op.b = ptc_pkg::MUL_B_W'(mag_e_reg);
            end
            ptc_pkg::ST_MKP: begin
                mul_op.a = kp_reg;
                mul_op.b = ptc_pkg::MUL_B_W'(mag_e_reg);
            end
            ptc_pkg::ST_MDT3: begin
                mul_op.a = dt_reg;
                mul_op.b = ptc_pkg::MUL_B_W'(p1_reg[ptc_pkg::P1_W-1:36]);
            end
            ptc_pkg::ST_MDT2: begin
                mul_op.a = dt_reg;
                mul_op.b = p1_reg[35:24];
            end
            ptc_pkg::ST_MDT1: begin
                mul_op.a = dt_reg;
                mul_op.b = p1_reg[23:12];
            end
            ptc_pkg::ST_MDT0: begin
                mul_op.a = dt_reg;
                mul_op.b = p1_reg[11:0];
            end
            default: mul_op = '0;
        endcase
    end

    ptc_mul u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .prod (mul_p)
    );

    always_comb begin
        div_req.start    = (state_reg == ptc_pkg::ST_MKI) && !dt_zero;
        div_req.dividend = {mul_p[ptc_pkg::DIVD_W-ptc_pkg::DIV_SHIFT-1:0],
                            {ptc_pkg::DIV_SHIFT{1'b0}}};
        div_req.divisor  = dt_reg;
    end

    ptc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // The elapsed-time product is built from the top slice of ki*|e| (bits 41:36) down, in 12-bit slices.
    assign acc_step = {acc_reg[ptc_pkg::ACC_W-13:0], 12'b0}
                    + {{(ptc_pkg::ACC_W-ptc_pkg::MUL_P_W){1'b0}}, mul_p};

    always_comb begin
        if (acc_reg[ptc_pkg::ACC_W-1:ptc_pkg::INTEG_W] != '0
            || acc_reg[ptc_pkg::INTEG_W-1:0] > cap) begin
            inc_next = {1'b0, cap} + 1'b1;
        end else begin
            inc_next = {1'b0, acc_reg[ptc_pkg::INTEG_W-1:0]};
        end
    end

    assign integ_sum = {2'b0, integ_reg} + {1'b0, inc_reg};
    assign integ_dec = ({1'b0, integ_reg} > inc_reg)
                     ? integ_reg - inc_reg[ptc_pkg::INTEG_W-1:0] : '0;

    always_comb begin
        if (mag_e_reg >= band_reg) begin
            integ_next = '0;
        end else if (!err_reg[ptc_pkg::ERR_W-1]) begin
            integ_next = (integ_sum > {2'b0, cap}) ? cap : integ_sum[ptc_pkg::INTEG_W-1:0];
        end else begin
            // A lowered limit can leave the old integral above the new cap.
            integ_next = (integ_dec > cap) ? cap : integ_dec;
        end
    end

    assign p_ext = {3'b0, pmag_reg, 12'b0};
    assign p_s   = err_reg[ptc_pkg::ERR_W-1] ? (~p_ext + 1'b1) : p_ext;
    assign d_ext = dt_zero ? '0 : {2'b0, div_q};
    assign d_s   = de_neg_reg ? (~d_ext + 1'b1) : d_ext;

    assign sum_hi = sum_reg[SW-1:ptc_pkg::FRAC_W];
    always_comb begin
        if (sum_reg[SW-1] || sum_reg == '0) begin
            drive_next = '0;
        end else if (sum_hi > (SW-ptc_pkg::FRAC_W)'(limit_reg)) begin
            drive_next = limit_reg;
        end else begin
            drive_next = sum_hi[ptc_pkg::LIM_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptc_pkg::ST_IDLE: if (in_beat) state_next = ptc_pkg::ST_MKD;
            ptc_pkg::ST_MKD:  state_next = ptc_pkg::ST_MKI;
            ptc_pkg::ST_MKI:  state_next = ptc_pkg::ST_MKP;
            ptc_pkg::ST_MKP:  state_next = ptc_pkg::ST_MDT3;
            ptc_pkg::ST_MDT3: state_next = ptc_pkg::ST_MDT2;
            ptc_pkg::ST_MDT2: state_next = ptc_pkg::ST_MDT1;
            ptc_pkg::ST_MDT1: state_next = ptc_pkg::ST_MDT0;
            ptc_pkg::ST_MDT0: state_next = ptc_pkg::ST_ACC;
            ptc_pkg::ST_ACC:  state_next = ptc_pkg::ST_INC;
            ptc_pkg::ST_INC:  state_next = ptc_pkg::ST_UPD;
            ptc_pkg::ST_UPD:  state_next = ptc_pkg::ST_WAIT;
            ptc_pkg::ST_WAIT: if (!div_busy) state_next = ptc_pkg::ST_SUM1;
            ptc_pkg::ST_SUM1: state_next = ptc_pkg::ST_SUM2;
            ptc_pkg::ST_SUM2: state_next = ptc_pkg::ST_OUT;
            ptc_pkg::ST_OUT:  if (out_load) state_next = ptc_pkg::ST_IDLE;
            default:          state_next = ptc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ptc_pkg::ST_IDLE;
            last_time_reg <= '0;
            last_err_reg  <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_beat) begin
                last_time_reg <= in_now;
                last_err_reg  <= err_in;
            end
            if (state_reg == ptc_pkg::ST_UPD) begin
                integ_reg <= integ_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            dt_reg     <= in_now - last_time_reg;
            err_reg    <= err_in;
            mag_e_reg  <= err_in[ptc_pkg::ERR_W-1] ? TW'(-err_in) : err_in[TW-1:0];
            mag_de_reg <= de_in[ptc_pkg::DERR_W-1] ? ptc_pkg::MAG_DE_W'(-de_in)
                                                   : de_in[ptc_pkg::MAG_DE_W-1:0];
            de_neg_reg <= de_in[ptc_pkg::DERR_W-1];
        end
        if (state_reg == ptc_pkg::ST_MKP) begin
            p1_reg <= mul_p[ptc_pkg::P1_W-1:0];
        end
        if (state_reg == ptc_pkg::ST_MDT3) begin
            pmag_reg <= mul_p[ptc_pkg::P1_W-1:0];
        end
        if (state_reg == ptc_pkg::ST_MDT2) begin
            acc_reg <= {{(ptc_pkg::ACC_W-ptc_pkg::MUL_P_W){1'b0}}, mul_p};
        end else if (state_reg == ptc_pkg::ST_MDT1 || state_reg == ptc_pkg::ST_MDT0
                     || state_reg == ptc_pkg::ST_ACC) begin
            acc_reg <= acc_step;
        end
        if (state_reg == ptc_pkg::ST_INC) begin
            inc_reg <= inc_next;
        end
        if (state_reg == ptc_pkg::ST_SUM1) begin
            sum_reg <= p_s + {{(SW-ptc_pkg::INTEG_W){1'b0}}, integ_reg};
        end else if (state_reg == ptc_pkg::ST_SUM2) begin
            sum_reg <= sum_reg + d_s;
        end
        if (out_load) begin
            out_drive_reg <= drive_next;
            out_flag_reg  <= dt_zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ptc_pkg::M_TDATA_W-ptc_pkg::LIM_W){1'b0}}, out_drive_reg};
    assign m_tuser  = out_flag_reg;

    // The divider must be finished whenever a new beat can be accepted.
    a_idle_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ptc_pkg::ST_IDLE |-> !div_busy)
        else $error("divider still busy while idle");

    // The integral never leaves the range 0 to output_limit * 2^32 (32 fraction bits).
    a_integ_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ptc_pkg::ST_UPD |-> integ_next <= cap)
        else $error("integral update exceeds cap");

    // A loaded result carries the elapsed-time flag of the beat just worked on.
    a_flag_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && (m_tuser == (dt_reg == '0)))
        else $error("no_elapsed_time flag mismatch");

endmodule

/* design/ptc_mul.sv */
// Shared 32x12 unsigned multiplier with a registered product.
module ptc_mul (
    input  logic                           aclk,
    input  ptc_pkg::mul_op_t               op,
    output logic [ptc_pkg::MUL_P_W-1:0]    prod
);

    logic [ptc_pkg::MUL_P_W-1:0] prod_reg;
    logic [ptc_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = ptc_pkg::MUL_P_W'(op.a) * ptc_pkg::MUL_P_W'(op.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* design/ptc_div.sv */
// Restoring divider, one quotient bit per cycle, for the derivative term.
module ptc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ptc_pkg::div_req_t             req,
    output logic                          busy,
    output logic [ptc_pkg::DIVD_W-1:0]    quotient
);

    logic [ptc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ptc_pkg::DIVD_W-1:0]    quo_reg, quo_next;
    logic [ptc_pkg::TIME_W-1:0]    rem_reg, rem_next;
    logic [ptc_pkg::TIME_W-1:0]    dvs_reg, dvs_next;
    logic [ptc_pkg::TIME_W:0]      shifted;
    logic [ptc_pkg::TIME_W:0]      diff;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[ptc_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (req.start) begin
            cnt_next = ptc_pkg::DIV_CNT_W'(ptc_pkg::DIVD_W);
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[ptc_pkg::DIVD_W-2:0], fits};
            // The partial remainder always stays below the divisor.
            rem_next = fits ? diff[ptc_pkg::TIME_W-1:0] : shifted[ptc_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the PID temperature controller with its own fixed-point predictor.
module tb;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [ptc_pkg::TEMP_W-1:0] drive;
        logic                       no_elapsed;
    } drive_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ptc_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [ptc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           cfg_we;
    logic [ptc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the configuration and the controller state.
    logic [ptc_pkg::GAIN_W-1:0] cur_kp, cur_ki, cur_kd;
    logic [ptc_pkg::LIM_W-1:0]  cur_band, cur_limit;
    logic [ptc_pkg::TIME_W-1:0] pid_last_ms;
    int                         pid_last_err;
    longint unsigned            pid_integ;

    drive_result_t pending_drives[$];

    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req_len = 0;
    int hold_req_id = 0;
    int hold_seen_id = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int ticks_sent = 0;
    int drives_checked = 0;
    int reg_writes = 0;
    int mismatch_count = 0;
    logic [ptc_pkg::TIME_W-1:0] sim_ms = '0;
    logic [ptc_pkg::TEMP_W-1:0] setpoint = 10'd200;

    pid_temperature_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Computes the drive for one control tick and advances the predictor state.
    function automatic drive_result_t predict_drive(input logic [ptc_pkg::TEMP_W-1:0] meas,
                                                    input logic [ptc_pkg::TEMP_W-1:0] tgt,
                                                    input logic [ptc_pkg::TIME_W-1:0] now);
        drive_result_t              res;
        logic [ptc_pkg::TIME_W-1:0] dt;
        int              err, mag_e, de, mag_de;
        longint unsigned cap, p1, inc, acc, num, quot, dq;
        longint          p_term, d_term, total;

        dt = now - pid_last_ms;
        err = int'(tgt) - int'(meas);
        mag_e = err < 0 ? -err : err;
        cap = {22'd0, cur_limit, 32'd0};

        if (mag_e < int'(cur_band)) begin
            p1 = 64'(cur_ki) * 64'(unsigned'(mag_e));
            if (p1 == 0 || dt == 0)
                inc = 0;
            else if (64'(dt) > cap / p1)
                inc = cap + 1;
            else
                inc = p1 * 64'(dt);
            if (err >= 0) begin
                acc = pid_integ + inc;
                pid_integ = acc > cap ? cap : acc;
            end else begin
                pid_integ = pid_integ > inc ? pid_integ - inc : 64'd0;
            end
            if (pid_integ > cap)
                pid_integ = cap;
        end else begin
            pid_integ = 0;
        end

        p_term = longint'((64'(cur_kp) * 64'(unsigned'(mag_e))) << 12);
        if (err < 0)
            p_term = -p_term;

        d_term = 0;
        if (dt != 0) begin
            de = err - pid_last_err;
            mag_de = de < 0 ? -de : de;
            num = (64'(cur_kd) * 64'(unsigned'(mag_de))) << 12;
            quot = num / 64'(dt);
            d_term = de < 0 ? -longint'(quot) : longint'(quot);
        end

        total = p_term + longint'(pid_integ) + d_term;
        if (total <= 0) begin
            dq = 0;
        end else begin
            dq = longint'(total) >>> 32;
            if (dq > 64'(cur_limit))
                dq = 64'(cur_limit);
        end

        pid_last_ms = now;
        pid_last_err = err;
        res.drive = dq[ptc_pkg::TEMP_W-1:0];
        res.no_elapsed = (dt == 0);
        return res;
    endfunction

    // Offers one tick and waits for its beat; s_tvalid is left high so a following
    // tick is offered straight away unless send_idle_pct draws idle cycles first.
    task automatic send_tick(input logic [ptc_pkg::TEMP_W-1:0] meas,
                             input logic [ptc_pkg::TEMP_W-1:0] tgt,
                             input logic [ptc_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, now, tgt, meas};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_drives.push_back(predict_drive(meas, tgt, now));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge aclk);
    endtask

    // Writes every register; the block must be idle.
    task automatic load_config(input logic [ptc_pkg::GAIN_W-1:0] kp,
                               input logic [ptc_pkg::GAIN_W-1:0] ki,
                               input logic [ptc_pkg::GAIN_W-1:0] kd,
                               input logic [ptc_pkg::LIM_W-1:0] band,
                               input logic [ptc_pkg::LIM_W-1:0] lim);
        cfg_we <= 1'b1;
        cfg_addr <= ptc_pkg::REG_KP_GAIN;
        cfg_wdata <= kp;
        @(posedge aclk);
        cfg_addr <= ptc_pkg::REG_KI_GAIN;
        cfg_wdata <= ki;
        @(posedge aclk);
        cfg_addr <= ptc_pkg::REG_KD_GAIN;
        cfg_wdata <= kd;
        @(posedge aclk);
        cfg_addr <= ptc_pkg::REG_ERROR_BAND;
        cfg_wdata <= 32'(band);
        @(posedge aclk);
        cfg_addr <= ptc_pkg::REG_OUTPUT_LIMIT;
        cfg_wdata <= 32'(lim);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_kp = kp;
        cur_ki = ki;
        cur_kd = kd;
        cur_band = band;
        cur_limit = lim;
        reg_writes += 5;
    endtask

    function automatic logic [ptc_pkg::GAIN_W-1:0] pick_gain(
        input logic [ptc_pkg::GAIN_W-1:0] nominal);
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom();
            default: return (nominal >> $urandom_range(3)) + $urandom_range(4095);
        endcase
    endfunction

    // Mostly a plant settling around a setpoint with sane time steps; the rest is
    // repeated timestamps, jumps across the counter wrap and arbitrary readings.
    task automatic send_random_tick();
        logic [ptc_pkg::TEMP_W-1:0] meas, tgt;
        int pick, v;

        pick = $urandom_range(99);
        if (pick < 10)
            sim_ms = sim_ms;
        else if (pick < 16)
            sim_ms = $urandom();
        else if (pick < 85)
            sim_ms += $urandom_range(1, 1000);
        else
            sim_ms += $urandom_range(1, 200000);
        if ($urandom_range(19) == 0)
            setpoint = ptc_pkg::TEMP_W'($urandom_range(1023));
        if ($urandom_range(99) < 15) begin
            meas = ptc_pkg::TEMP_W'($urandom_range(1023));
            tgt = ptc_pkg::TEMP_W'($urandom_range(1023));
        end else begin
            v = int'(setpoint) - 30 + int'($urandom_range(60));
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
            meas = v[ptc_pkg::TEMP_W-1:0];
            tgt = setpoint;
        end
        send_tick(meas, tgt, sim_ms);
    endtask

    task automatic test_reset_defaults();
        send_tick(10'd25, 10'd25, 32'd0);
        send_tick(10'd25, 10'd30, 32'd500);
        send_tick(10'd25, 10'd30, 32'd1000);
        send_tick(10'd30, 10'd25, 32'd1500);
        send_tick(10'd0, 10'd1023, 32'd2000);
        send_tick(10'd1023, 10'd0, 32'd2500);
        send_tick(10'd1023, 10'd1023, 32'd2500);
        send_tick(10'd100, 10'd119, 32'hFFFF_FF00);
        send_tick(10'd100, 10'd119, 32'h0000_0010);
        send_tick(10'd100, 10'd120, 32'h0000_0200);
        send_tick(10'd120, 10'd100, 32'hFFFF_FFFF);
        send_tick(10'd100, 10'd101, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        // No integration at all with a zero band.
        load_config(ptc_pkg::KP_RESET, ptc_pkg::KI_RESET, ptc_pkg::KD_RESET, 10'd0,
                    ptc_pkg::LIM_RESET);
        send_tick(10'd50, 10'd60, 32'd3000);
        send_tick(10'd60, 10'd60, 32'd3100);
        wait_drained();
        load_config('1, '1, '1, 10'd1023, 10'd1023);
        send_tick(10'd0, 10'd1023, 32'd3101);
        send_tick(10'd1023, 10'd0, 32'd3102);
        send_tick(10'd500, 10'd510, 32'd3110);
        send_tick(10'd510, 10'd500, 32'd3110);
        wait_drained();
        // Integral increment far beyond 64 bits must saturate at the limit.
        load_config('0, '1, '0, 10'd1023, 10'd1);
        send_tick(10'd0, 10'd1022, 32'd4000000000);
        send_tick(10'd1022, 10'd0, 32'd4000000001);
        wait_drained();
        load_config('0, '0, '0, 10'd1023, 10'd1023);
        send_tick(10'd0, 10'd1023, 32'd4000000002);
        send_tick(10'd700, 10'd300, 32'd4000000500);
        wait_drained();
        load_config(ptc_pkg::KP_RESET, ptc_pkg::KI_RESET, ptc_pkg::KD_RESET,
                    ptc_pkg::BAND_RESET, ptc_pkg::LIM_RESET);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        logic [ptc_pkg::LIM_W-1:0] band, lim;

        wait_drained();
        case ($urandom_range(3))
            0: band = 10'd0;
            1: band = 10'd1023;
            2: band = ptc_pkg::LIM_W'($urandom_range(1023));
            default: band = ptc_pkg::LIM_W'($urandom_range(5, 40));
        endcase
        case ($urandom_range(3))
            0: lim = 10'd1;
            1: lim = 10'd1023;
            default: lim = ptc_pkg::LIM_W'($urandom_range(1, 1023));
        endcase
        load_config(pick_gain(ptc_pkg::KP_RESET), pick_gain(ptc_pkg::KI_RESET),
                    pick_gain(ptc_pkg::KD_RESET), band, lim);
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            send_random_tick();
        wait_drained();
    endtask

    // The receiver holds off long enough for a result to sit in the output
    // register while the sender keeps offering beats.
    task automatic test_output_backpressure();
        wait_drained();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req_len = 400;
        hold_req_id++;
        repeat (40)
            send_random_tick();
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req_id != hold_seen_id) begin
            hold_seen_id = hold_req_id;
            hold_left = hold_req_len;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        drive_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drives.size() == 0) begin
                $error("unexpected result beat: drive %0d no_elapsed_time %0d",
                       m_tdata[ptc_pkg::TEMP_W-1:0], m_tuser);
                mismatch_count++;
            end else begin
                want = pending_drives.pop_front();
                drives_checked++;
                if (m_tdata[ptc_pkg::TEMP_W-1:0] !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive,
                           m_tdata[ptc_pkg::TEMP_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.no_elapsed) begin
                    $error("no_elapsed_time: expected %0d, got %0d", want.no_elapsed, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        cur_kp = ptc_pkg::KP_RESET;
        cur_ki = ptc_pkg::KI_RESET;
        cur_kd = ptc_pkg::KD_RESET;
        cur_band = ptc_pkg::BAND_RESET;
        cur_limit = ptc_pkg::LIM_RESET;
        pid_last_ms = '0;
        pid_last_err = 0;
        pid_integ = 0;
        repeat (7)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_config_extremes();
        test_random_traffic(0, 0, 197);
        test_random_traffic(51, 0, 197);
        test_random_traffic(0, 51, 197);
        test_random_traffic(20, 20, 197);
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
        $display("Sent %0d control ticks and checked %0d drive results across %0d register writes,",
                 ticks_sent, drives_checked, reg_writes);
        $display("including gain extremes, counter wrap, zero elapsed time and output back-pressure.");
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
